// File: src/gaa_pkg.sv
// Shared types, codes and sizes of the grouped aggregate accumulator.
package gaa_pkg;

   // Default sizes handed to the top level parameters.
   localparam int NUM_GROUPS_DEFAULT = 1024;
   localparam int COUNT_BITS_DEFAULT = 48;

   // Fixed field widths of the request and response words.
   localparam int GROUP_BITS     = 10;
   localparam int VALUE_BITS     = 64;
   localparam int ROW_COUNT_BITS = 48;
   localparam int STATUS_BITS    = 3;
   localparam int MODE_BITS      = 2;
   localparam int KIND_BITS      = 4;

   // Widest group address that the parameter range can call for, plus one bit.
   localparam int WIDE_ADDR_BITS = 17;

   // Queue between front and back, and the response queue.
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_DEPTH        = 4;
   localparam int RSP_PTR_BITS     = $clog2(RSP_DEPTH);
   localparam int RSP_LEVEL_BITS   = $clog2(RSP_DEPTH + 1);

   // Register port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_REG_AGG_KIND     = 1'b0;
   localparam logic CSR_REG_DROP_MISSING = 1'b1;

   // Request modes.
   localparam logic [MODE_BITS-1:0] MODE_FEED = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_READ = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_INIT = 2'd2;

   // Aggregate kinds.
   localparam logic [KIND_BITS-1:0] AGG_COUNT_ALL   = 4'd0;
   localparam logic [KIND_BITS-1:0] AGG_COUNT_VALID = 4'd1;
   localparam logic [KIND_BITS-1:0] AGG_SUM         = 4'd2;
   localparam logic [KIND_BITS-1:0] AGG_AVERAGE     = 4'd3;
   localparam logic [KIND_BITS-1:0] AGG_MIN         = 4'd4;
   localparam logic [KIND_BITS-1:0] AGG_MAX         = 4'd5;
   localparam logic [KIND_BITS-1:0] AGG_EARLIEST    = 4'd6;
   localparam logic [KIND_BITS-1:0] AGG_LATEST      = 4'd7;
   localparam logic [KIND_BITS-1:0] AGG_ANY         = 4'd8;
   localparam logic [KIND_BITS-1:0] AGG_ALL         = 4'd9;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_VALUE   = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NA      = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_POS_INF = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NEG_INF = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_NAN     = 3'd4;

   // Operation that the front hands to the back.
   typedef enum logic [1:0] {
      OP_FEED      = 2'd0,
      OP_READ      = 2'd1,
      OP_INIT      = 2'd2,
      OP_READ_MISS = 2'd3
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [GROUP_BITS-1:0]         group;
      logic signed [VALUE_BITS-1:0]  value;
      logic                          value_valid;
   } item_word_type;

   typedef struct packed {
      logic [GROUP_BITS-1:0]         group_out;
      logic [STATUS_BITS-1:0]        status;
      logic signed [VALUE_BITS-1:0]  result_value;
      logic [ROW_COUNT_BITS-1:0]     row_count;
   } rsp_word_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] agg_kind;
      logic                 drop_missing;
   } cfg_type;

endpackage

// File: src/gaa_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module gaa_front #(
   parameter int NUM_GROUPS = gaa_pkg::NUM_GROUPS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [gaa_pkg::MODE_BITS-1:0]          req_mode,
   input  logic [gaa_pkg::GROUP_BITS-1:0]         req_group_index,
   input  logic signed [gaa_pkg::VALUE_BITS-1:0]  req_value_in,
   input  logic                                   req_value_valid,
   input  logic                                   hold,
   output logic                                   q_valid,
   output gaa_pkg::item_word_type                 q_word,
   input  logic                                   q_pop
);
   import gaa_pkg::*;

   logic                          in_range;
   logic                          keep;
   op_type                        op;
   logic                          accept;
   logic                          push;
   item_word_type                 word_in;
   item_word_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_BITS-1:0]   level_ff, level_in;

   // Classify the word: unused modes are dropped, as are groups past the table except for reads, which answer NA.
   always_comb begin
      in_range = WIDE_ADDR_BITS'(req_group_index) < WIDE_ADDR_BITS'(NUM_GROUPS);
      keep     = 1'b0;
      op       = OP_FEED;
      case (req_mode)
         MODE_FEED: begin
            keep = in_range;
            op   = OP_FEED;
         end
         MODE_READ: begin
            keep = 1'b1;
            op   = in_range ? OP_READ : OP_READ_MISS;
         end
         MODE_INIT: begin
            keep = in_range;
            op   = OP_INIT;
         end
         default: begin
            keep = 1'b0;
            op   = OP_FEED;
         end
      endcase
   end

   assign req_full = (level_ff == QUEUE_LEVEL_BITS'(QUEUE_DEPTH)) | hold;
   assign accept   = req_push & ~req_full;
   assign push     = accept & keep;

   assign word_in.op          = op;
   assign word_in.group       = req_group_index;
   assign word_in.value       = req_value_in;
   assign word_in.value_valid = req_value_valid;

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push  ? QUEUE_PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? QUEUE_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff + QUEUE_LEVEL_BITS'(push) - QUEUE_LEVEL_BITS'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Queue storage holds only payload.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word_in;
      end
   end

   assign q_valid = (level_ff != '0);
   assign q_word  = slot_ff[rd_ptr_ff];

endmodule

// File: src/gaa_back.sv
// Back end: group table with a read-modify-write pipeline, forwarding and a clearing pass.
module gaa_back #(
   parameter int NUM_GROUPS = gaa_pkg::NUM_GROUPS_DEFAULT,
   parameter int COUNT_BITS = gaa_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gaa_pkg::cfg_type                      cfg,
   input  logic                                  q_valid,
   input  gaa_pkg::item_word_type                q_word,
   output logic                                  q_pop,
   output logic                                  clearing,
   input  logic [gaa_pkg::RSP_LEVEL_BITS-1:0]    rsp_level,
   output logic                                  rsp_push,
   output gaa_pkg::rsp_word_type                 rsp_word
);
   import gaa_pkg::*;

   localparam int ADDR_BITS = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int ROOM_BITS = RSP_LEVEL_BITS + 1;

   typedef struct packed {
      logic [COUNT_BITS-1:0]         count;
      logic signed [VALUE_BITS-1:0]  accum;
      logic                          flag;
      logic                          poisoned;
   } entry_type;

   function automatic logic [ADDR_BITS-1:0] addr_of(input logic [GROUP_BITS-1:0] group);
      logic [WIDE_ADDR_BITS-1:0] wide;
      wide = WIDE_ADDR_BITS'(group);
      return wide[ADDR_BITS-1:0];
   endfunction

   entry_type                 group_mem [0:NUM_GROUPS-1];
   entry_type                 rd_entry_ff;
   logic                      rd_en;
   logic [ADDR_BITS-1:0]      pop_addr;

   logic                      clearing_ff, clearing_in;
   logic [ADDR_BITS-1:0]      clear_addr_ff, clear_addr_in;
   logic                      clear_last;

   logic                      b_valid_ff, b_valid_in;
   item_word_type             b_word_ff;
   logic [ADDR_BITS-1:0]      b_addr;
   logic                      b_we;
   logic                      b_rsp;

   logic                      fwd_hit_ff, fwd_hit_in;
   entry_type                 fwd_entry_ff;

   entry_type                 cur_entry;
   entry_type                 new_entry;
   logic [COUNT_BITS-1:0]     count_bump;
   logic [63:0]               count_wide;
   logic                      room;

   logic                      mem_we;
   logic [ADDR_BITS-1:0]      mem_waddr;
   entry_type                 mem_wdata;

   // Clearing pass walks the table once after reset.
   assign clear_last = (clear_addr_ff == ADDR_BITS'(NUM_GROUPS - 1));
   always_comb begin
      clearing_in   = clearing_ff & ~clear_last;
      clear_addr_in = clearing_ff ? ADDR_BITS'(clear_addr_ff + 1'b1) : clear_addr_ff;
   end
   assign clearing = clearing_ff;

   // Issue: take a word when the response queue is sure to have room for it.
   assign b_rsp = b_valid_ff & (b_word_ff.op inside {OP_READ, OP_READ_MISS});
   assign room  = (ROOM_BITS'(rsp_level) + ROOM_BITS'(b_rsp)) < ROOM_BITS'(RSP_DEPTH);
   assign q_pop = q_valid & ~clearing_ff & room;

   assign pop_addr = addr_of(q_word.group);
   assign rd_en    = q_pop & (q_word.op != OP_READ_MISS);

   assign b_addr = addr_of(b_word_ff.group);
   assign b_we   = b_valid_ff & (b_word_ff.op inside {OP_FEED, OP_INIT});

   // A write in flight to the same group overtakes the stale memory word.
   assign b_valid_in = q_pop;
   assign fwd_hit_in = q_pop & b_we & (q_word.group == b_word_ff.group);
   assign cur_entry  = fwd_hit_ff ? fwd_entry_ff : rd_entry_ff;

   // Update of one group entry for a feed or an init word.
   always_comb begin
      new_entry  = cur_entry;
      count_bump = (&cur_entry.count) ? cur_entry.count
                                      : cur_entry.count + COUNT_BITS'(1);
      if (b_word_ff.op == OP_INIT) begin
         new_entry      = '0;
         new_entry.flag = (cfg.agg_kind == AGG_ALL);
      end else if (cfg.agg_kind == AGG_COUNT_ALL) begin
         new_entry.count = count_bump;
      end else if (cfg.agg_kind <= AGG_ALL) begin
         if (!b_word_ff.value_valid) begin
            if ((cfg.agg_kind != AGG_COUNT_VALID) && !cfg.drop_missing) begin
               new_entry.poisoned = 1'b1;
            end
         end else begin
            new_entry.count = count_bump;
            case (cfg.agg_kind)
               AGG_SUM, AGG_AVERAGE: begin
                  new_entry.accum = cur_entry.accum + b_word_ff.value;
               end
               AGG_MIN: begin
                  if (!cur_entry.flag || ($signed(b_word_ff.value) < $signed(cur_entry.accum))) begin
                     new_entry.accum = b_word_ff.value;
                     new_entry.flag  = 1'b1;
                  end
               end
               AGG_MAX: begin
                  if (!cur_entry.flag || ($signed(cur_entry.accum) < $signed(b_word_ff.value))) begin
                     new_entry.accum = b_word_ff.value;
                     new_entry.flag  = 1'b1;
                  end
               end
               AGG_EARLIEST: begin
                  if (!cur_entry.flag) begin
                     new_entry.accum = b_word_ff.value;
                     new_entry.flag  = 1'b1;
                  end
               end
               AGG_LATEST: begin
                  new_entry.accum = b_word_ff.value;
                  new_entry.flag  = 1'b1;
               end
               AGG_ANY: begin
                  if (b_word_ff.value != '0) begin
                     new_entry.flag = 1'b1;
                  end
               end
               AGG_ALL: begin
                  if (b_word_ff.value == '0) begin
                     new_entry.flag = 1'b0;
                  end
               end
               default: begin
                  new_entry.count = count_bump;
               end
            endcase
         end
      end
   end

   // Response word for a read.
   always_comb begin
      count_wide            = 64'(cur_entry.count);
      rsp_word.group_out    = b_word_ff.group;
      rsp_word.status       = STATUS_VALUE;
      rsp_word.result_value = '0;
      rsp_word.row_count    = count_wide[ROW_COUNT_BITS-1:0];
      if (b_word_ff.op == OP_READ_MISS) begin
         rsp_word.status    = STATUS_NA;
         rsp_word.row_count = '0;
      end else begin
         case (cfg.agg_kind)
            AGG_COUNT_ALL, AGG_COUNT_VALID: begin
               rsp_word.result_value = count_wide;
            end
            AGG_SUM: begin
               if (cur_entry.poisoned) rsp_word.status = STATUS_NA;
               else rsp_word.result_value = cur_entry.accum;
            end
            AGG_AVERAGE: begin
               if (cur_entry.poisoned) rsp_word.status = STATUS_NA;
               else if (cur_entry.count == '0) rsp_word.status = STATUS_NAN;
               else rsp_word.result_value = cur_entry.accum;
            end
            AGG_MIN, AGG_MAX: begin
               if (cur_entry.poisoned) begin
                  rsp_word.status = STATUS_NA;
               end else if (!cur_entry.flag) begin
                  rsp_word.status = (cfg.agg_kind == AGG_MIN) ? STATUS_POS_INF : STATUS_NEG_INF;
               end else begin
                  rsp_word.result_value = cur_entry.accum;
               end
            end
            AGG_EARLIEST, AGG_LATEST: begin
               if (cur_entry.poisoned || !cur_entry.flag) rsp_word.status = STATUS_NA;
               else rsp_word.result_value = cur_entry.accum;
            end
            AGG_ANY, AGG_ALL: begin
               if (cur_entry.poisoned) rsp_word.status = STATUS_NA;
               else rsp_word.result_value = VALUE_BITS'(cur_entry.flag);
            end
            default: begin
               rsp_word.status = STATUS_NA;
            end
         endcase
      end
   end

   assign rsp_push = b_rsp;

   // Table write port: zeros during the clearing pass, else the updated entry.
   always_comb begin
      mem_we    = clearing_ff | b_we;
      mem_waddr = clearing_ff ? clear_addr_ff : b_addr;
      mem_wdata = clearing_ff ? entry_type'('0) : new_entry;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         group_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_entry_ff <= group_mem[pop_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         b_valid_ff    <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         b_valid_ff    <= b_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_word_ff <= q_word;
      end
      if (fwd_hit_in) begin
         fwd_entry_ff <= new_entry;
      end
   end

endmodule

// File: src/gaa_rsp_queue.sv
// Response queue that holds finished read results until they are taken.
module gaa_rsp_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  gaa_pkg::rsp_word_type                 word_in,
   output logic [gaa_pkg::RSP_LEVEL_BITS-1:0]    level,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output gaa_pkg::rsp_word_type                 head
);
   import gaa_pkg::*;

   rsp_word_type                slot_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RSP_LEVEL_BITS-1:0]   level_ff, level_in;
   logic                        pop;

   assign rsp_empty = (level_ff == '0);
   assign pop       = rsp_pop & ~rsp_empty;

   // Pointers and fill level; the back end only pushes when there is room.
   always_comb begin
      wr_ptr_in = push ? RSP_PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? RSP_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff + RSP_LEVEL_BITS'(push) - RSP_LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word_in;
      end
   end

   assign level = level_ff;
   assign head  = slot_ff[rd_ptr_ff];

endmodule

// File: src/grouped_aggregate_accumulator_core.sv
// Top level of the grouped aggregate accumulator: register port and the three datapath parts.
//
// The core keeps one accumulator per group and applies the aggregate selected in agg_kind
// to feed words; a read word returns one result word, init clears one group. Unless it is
// clearing or short of response room, it sustains one request word per clock: the group
// table is a single memory with a registered read, and a forwarding register hands an
// update straight to a following word for the same group, so repeated rows to one group
// do not stall. A read result reaches the response side through the front queue, the
// back-end stage register and the response queue. After reset the core clears every table
// entry, one per cycle, and holds req_full high meanwhile; register writes are taken then.
// Change agg_kind or drop_missing only while no words are in flight.
module grouped_aggregate_accumulator_core #(
   parameter int NUM_GROUPS = gaa_pkg::NUM_GROUPS_DEFAULT,
   parameter int COUNT_BITS = gaa_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Request side.
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic [gaa_pkg::MODE_BITS-1:0]            req_mode,
   input  logic [gaa_pkg::GROUP_BITS-1:0]           req_group_index,
   input  logic signed [gaa_pkg::VALUE_BITS-1:0]    req_value_in,
   input  logic                                     req_value_valid,
   // Response side.
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic [gaa_pkg::GROUP_BITS-1:0]           rsp_group_out,
   output logic [gaa_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic signed [gaa_pkg::VALUE_BITS-1:0]    rsp_result_value,
   output logic [gaa_pkg::ROW_COUNT_BITS-1:0]       rsp_row_count,
   // Register port.
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [gaa_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  logic [gaa_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [gaa_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                     csr_pready
);
   import gaa_pkg::*;

   logic [KIND_BITS-1:0]       agg_kind_ff, agg_kind_in;
   logic                       drop_missing_ff, drop_missing_in;
   logic                       csr_write;
   logic                       csr_reg;
   cfg_type                    cfg;

   logic                       clearing;
   logic                       q_valid;
   item_word_type              q_word;
   logic                       q_pop;
   logic                       rsp_push;
   rsp_word_type               rsp_word;
   rsp_word_type               rsp_head;
   logic [RSP_LEVEL_BITS-1:0]  rsp_level;

   // Register port: each register sits at its own word address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg    = csr_paddr[2];

   always_comb begin
      agg_kind_in     = agg_kind_ff;
      drop_missing_in = drop_missing_ff;
      if (csr_write) begin
         case (csr_reg)
            CSR_REG_AGG_KIND:     agg_kind_in     = csr_pwdata[KIND_BITS-1:0];
            CSR_REG_DROP_MISSING: drop_missing_in = csr_pwdata[0];
            default:              agg_kind_in     = agg_kind_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         CSR_REG_AGG_KIND:     csr_prdata = CSR_DATA_BITS'(agg_kind_ff);
         CSR_REG_DROP_MISSING: csr_prdata = CSR_DATA_BITS'(drop_missing_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agg_kind_ff     <= AGG_COUNT_ALL;
         drop_missing_ff <= 1'b0;
      end else begin
         agg_kind_ff     <= agg_kind_in;
         drop_missing_ff <= drop_missing_in;
      end
   end

   assign cfg.agg_kind     = agg_kind_ff;
   assign cfg.drop_missing = drop_missing_ff;

   // Front end with its queue.
   gaa_front #(
      .NUM_GROUPS (NUM_GROUPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_group_index (req_group_index),
      .req_value_in    (req_value_in),
      .req_value_valid (req_value_valid),
      .hold            (clearing),
      .q_valid         (q_valid),
      .q_word          (q_word),
      .q_pop           (q_pop)
   );

   // Back end with the group table.
   gaa_back #(
      .NUM_GROUPS (NUM_GROUPS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word)
   );

   // Response queue.
   gaa_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .word_in   (rsp_word),
      .level     (rsp_level),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_group_out    = rsp_head.group_out;
   assign rsp_status       = rsp_head.status;
   assign rsp_result_value = rsp_head.result_value;
   assign rsp_row_count    = rsp_head.row_count;

endmodule

// File: sim/grouped_aggregate_accumulator_core_tb.sv
// Self-checking testbench for the grouped aggregate accumulator core.
module grouped_aggregate_accumulator_core_tb;
   import gaa_pkg::*;

   localparam int GROUP_TOTAL = NUM_GROUPS_DEFAULT;
   localparam int COUNT_WIDTH = COUNT_BITS_DEFAULT;

   // Codes that the package leaves unnamed.
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam logic [KIND_BITS-1:0] AGG_UNUSED  = 4'd15;

   // Register addresses: one 32-bit register per 4 bytes.
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_AGG_KIND     = {CSR_REG_AGG_KIND, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_DROP_MISSING = {CSR_REG_DROP_MISSING, 2'b00};

   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_push        = 1'b0;
   logic                          req_full;
   logic [MODE_BITS-1:0]          req_mode        = '0;
   logic [GROUP_BITS-1:0]         req_group_index = '0;
   logic signed [VALUE_BITS-1:0]  req_value_in    = '0;
   logic                          req_value_valid = 1'b0;

   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [GROUP_BITS-1:0]         rsp_group_out;
   logic [STATUS_BITS-1:0]        rsp_status;
   logic signed [VALUE_BITS-1:0]  rsp_result_value;
   logic [ROW_COUNT_BITS-1:0]     rsp_row_count;

   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]      csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]      csr_prdata;
   logic                          csr_pready;

   // Predicted group table and configuration.
   logic [COUNT_WIDTH-1:0]        grp_count [GROUP_TOTAL];
   logic signed [VALUE_BITS-1:0]  grp_accum [GROUP_TOTAL];
   bit                            grp_flag  [GROUP_TOTAL];
   bit                            grp_poison[GROUP_TOTAL];
   logic [KIND_BITS-1:0]          cfg_kind = AGG_COUNT_ALL;
   logic                          cfg_drop = 1'b0;

   // Result words still owed by the core, oldest first.
   rsp_word_type expected_reads[$];

   int mismatch_count    = 0;
   bit reset_released    = 1'b0;
   bit no_gaps           = 1'b0;
   int rsp_hold_cycles   = 0;

   grouped_aggregate_accumulator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_group_index  (req_group_index),
      .req_value_in     (req_value_in),
      .req_value_valid  (req_value_valid),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_group_out    (rsp_group_out),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_row_count    (rsp_row_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #6 clock = ~clock;

   // Run limit, far beyond the slowest correct run.
   initial begin
      #(12 * 300000);
      $display("grouped_aggregate_accumulator_core verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) begin
         $display("ERROR: %s", what);
      end
      mismatch_count++;
   endtask

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 3);
   endfunction

   // Mix of small values, the extremes, zero and raw random patterns.
   function automatic logic signed [VALUE_BITS-1:0] draw_value();
      case ($urandom_range(0, 5))
         0: return $signed(64'($urandom_range(0, 16))) - 64'sd8;
         1: return VALUE_MAX;
         2: return VALUE_MIN;
         3: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void bump_count(input logic [GROUP_BITS-1:0] g);
      if (grp_count[g] != '1) begin
         grp_count[g] = grp_count[g] + 1'b1;
      end
   endfunction

   // Folds one row into its group under the current aggregate.
   function automatic void apply_feed(input logic [GROUP_BITS-1:0] g,
                                      input logic signed [VALUE_BITS-1:0] v,
                                      input logic valid);
      if (cfg_kind == AGG_COUNT_ALL) begin
         bump_count(g);
         return;
      end
      if (cfg_kind > AGG_ALL) begin
         return;
      end
      // A missing value poisons the group unless it is dropped.
      if (!valid) begin
         if (cfg_kind != AGG_COUNT_VALID && !cfg_drop) begin
            grp_poison[g] = 1'b1;
         end
         return;
      end
      bump_count(g);
      case (cfg_kind)
         AGG_SUM, AGG_AVERAGE: grp_accum[g] = grp_accum[g] + v;
         AGG_MIN: begin
            if (!grp_flag[g] || v < grp_accum[g]) begin
               grp_accum[g] = v;
               grp_flag[g] = 1'b1;
            end
         end
         AGG_MAX: begin
            if (!grp_flag[g] || grp_accum[g] < v) begin
               grp_accum[g] = v;
               grp_flag[g] = 1'b1;
            end
         end
         AGG_EARLIEST: begin
            if (!grp_flag[g]) begin
               grp_accum[g] = v;
               grp_flag[g] = 1'b1;
            end
         end
         AGG_LATEST: begin
            grp_accum[g] = v;
            grp_flag[g] = 1'b1;
         end
         AGG_ANY: begin
            if (v != 0) begin
               grp_flag[g] = 1'b1;
            end
         end
         AGG_ALL: begin
            if (v == 0) begin
               grp_flag[g] = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // Result word that a read of the group must return.
   function automatic rsp_word_type read_result(input logic [GROUP_BITS-1:0] g);
      rsp_word_type r;
      r.group_out    = g;
      r.status       = STATUS_VALUE;
      r.result_value = '0;
      r.row_count    = grp_count[g];
      case (cfg_kind)
         AGG_COUNT_ALL, AGG_COUNT_VALID: r.result_value = 64'(grp_count[g]);
         AGG_SUM: begin
            if (grp_poison[g]) r.status = STATUS_NA;
            else r.result_value = grp_accum[g];
         end
         AGG_AVERAGE: begin
            if (grp_poison[g]) r.status = STATUS_NA;
            else if (grp_count[g] == 0) r.status = STATUS_NAN;
            else r.result_value = grp_accum[g];
         end
         AGG_MIN, AGG_MAX: begin
            if (grp_poison[g]) r.status = STATUS_NA;
            else if (!grp_flag[g])
               r.status = (cfg_kind == AGG_MIN) ? STATUS_POS_INF : STATUS_NEG_INF;
            else r.result_value = grp_accum[g];
         end
         AGG_EARLIEST, AGG_LATEST: begin
            if (grp_poison[g] || !grp_flag[g]) r.status = STATUS_NA;
            else r.result_value = grp_accum[g];
         end
         AGG_ANY, AGG_ALL: begin
            if (grp_poison[g]) r.status = STATUS_NA;
            else r.result_value = 64'(grp_flag[g]);
         end
         default: r.status = STATUS_NA;
      endcase
      return r;
   endfunction

   // Updates the predicted table for one accepted request word.
   function automatic void predict_word(input logic [MODE_BITS-1:0] mode,
                                        input logic [GROUP_BITS-1:0] g,
                                        input logic signed [VALUE_BITS-1:0] v,
                                        input logic valid);
      case (mode)
         MODE_FEED: apply_feed(g, v, valid);
         MODE_INIT: begin
            grp_count[g]  = '0;
            grp_accum[g]  = '0;
            grp_poison[g] = 1'b0;
            grp_flag[g]   = (cfg_kind == AGG_ALL);
         end
         MODE_READ: expected_reads.push_back(read_result(g));
         default: ;
      endcase
   endfunction

   // Offers one request word after a random gap and waits until it is taken.
   task automatic send_word(input logic [MODE_BITS-1:0] mode,
                            input logic [GROUP_BITS-1:0] g,
                            input logic signed [VALUE_BITS-1:0] v,
                            input logic valid);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock) req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push        <= 1'b1;
      req_mode        <= mode;
      req_group_index <= g;
      req_value_in    <= v;
      req_value_valid <= valid;
      do @(posedge clock); while (req_full !== 1'b0);
      predict_word(mode, g, v, valid);
   endtask

   // Stops offering words, waits for every owed result, then lets the pipeline empty.
   task automatic wait_for_drain();
      int waited;
      @(negedge clock) req_push <= 1'b0;
      waited = 0;
      while (expected_reads.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
   endtask

   // One register transfer: setup cycle, then access cycle.
   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] want);
      logic [CSR_DATA_BITS-1:0] rdata;
      csr_access(1'b0, addr, '0, rdata);
      if (rdata !== want) begin
         report_mismatch($sformatf("register at %0d reads %h, expected %h", addr, rdata, want));
      end
   endtask

   // Writes both registers with junk in the unused bits and reads them back.
   task automatic set_config(input logic [KIND_BITS-1:0] kind, input logic drop);
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [CSR_DATA_BITS-1:0] rdata;
      wdata = $urandom;
      wdata[KIND_BITS-1:0] = kind;
      csr_access(1'b1, ADDR_AGG_KIND, wdata, rdata);
      wdata = $urandom;
      wdata[0] = drop;
      csr_access(1'b1, ADDR_DROP_MISSING, wdata, rdata);
      cfg_kind = kind;
      cfg_drop = drop;
      check_csr(ADDR_AGG_KIND, {28'd0, kind});
      check_csr(ADDR_DROP_MISSING, {31'd0, drop});
   endtask

   // Compares the word just popped with the oldest prediction.
   task automatic check_result();
      rsp_word_type want;
      if (expected_reads.size() == 0) begin
         report_mismatch($sformatf("result word for group %0d with none owed", rsp_group_out));
         return;
      end
      want = expected_reads.pop_front();
      if (rsp_group_out !== want.group_out)
         report_mismatch($sformatf("group_out %0d, expected %0d", rsp_group_out,
                                   want.group_out));
      if (rsp_status !== want.status)
         report_mismatch($sformatf("group %0d status %0d, expected %0d", want.group_out,
                                   rsp_status, want.status));
      if (rsp_result_value !== want.result_value)
         report_mismatch($sformatf("group %0d result_value %0d, expected %0d",
                                   want.group_out, rsp_result_value, want.result_value));
      if (rsp_row_count !== want.row_count)
         report_mismatch($sformatf("group %0d row_count %0d, expected %0d", want.group_out,
                                   rsp_row_count, want.row_count));
   endtask

   // Result side: random stalls, an optional long hold-off, one check per word.
   initial begin : result_side
      int stall;
      wait (reset_released);
      forever begin
         stall = draw_gap();
         @(negedge clock);
         if (stall > 0 || rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
            while (rsp_hold_cycles > 0) begin
               @(negedge clock);
               rsp_hold_cycles--;
            end
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         check_result();
      end
   end

   // Registers must come out of reset as zero.
   task automatic test_register_defaults();
      check_csr(ADDR_AGG_KIND, '0);
      check_csr(ADDR_DROP_MISSING, '0);
   endtask

   task automatic test_directed_cases();
      // All reads false before any init; init makes it true, a zero makes it false.
      set_config(AGG_ALL, 1'b0);
      send_word(MODE_READ, 10'd1023, '0, 1'b0);
      send_word(MODE_INIT, 10'd1023, VALUE_MIN, 1'b1);
      send_word(MODE_READ, 10'd1023, '0, 1'b1);
      send_word(MODE_FEED, 10'd1023, '0, 1'b1);
      send_word(MODE_READ, 10'd1023, VALUE_MAX, 1'b1);
      wait_for_drain();

      // The sum wraps, and a missing value poisons the group.
      set_config(AGG_SUM, 1'b0);
      send_word(MODE_INIT, 10'd0, '0, 1'b0);
      send_word(MODE_FEED, 10'd0, VALUE_MAX, 1'b1);
      send_word(MODE_FEED, 10'd0, VALUE_MAX, 1'b1);
      send_word(MODE_READ, 10'd0, '0, 1'b0);
      send_word(MODE_FEED, 10'd0, 64'sd5, 1'b0);
      send_word(MODE_READ, 10'd0, '0, 1'b0);
      wait_for_drain();

      // Mean of an empty group is NaN; with drop-missing a missing value is skipped.
      set_config(AGG_AVERAGE, 1'b1);
      send_word(MODE_INIT, 10'd512, '0, 1'b0);
      send_word(MODE_READ, 10'd512, '0, 1'b0);
      send_word(MODE_FEED, 10'd512, VALUE_MAX, 1'b0);
      send_word(MODE_FEED, 10'd512, VALUE_MIN, 1'b1);
      send_word(MODE_READ, 10'd512, '0, 1'b0);
      wait_for_drain();

      // An empty group reads +Inf for min, -Inf for max, NA for first and 0 for sum.
      set_config(AGG_MIN, 1'b1);
      send_word(MODE_INIT, 10'd300, '0, 1'b0);
      send_word(MODE_READ, 10'd300, '0, 1'b0);
      wait_for_drain();
      set_config(AGG_MAX, 1'b1);
      send_word(MODE_READ, 10'd300, '0, 1'b0);
      wait_for_drain();
      set_config(AGG_EARLIEST, 1'b1);
      send_word(MODE_READ, 10'd300, '0, 1'b0);
      wait_for_drain();
      set_config(AGG_SUM, 1'b1);
      send_word(MODE_READ, 10'd300, '0, 1'b0);
      wait_for_drain();

      // An unused kind changes nothing and reads NA; an unused mode is dropped.
      set_config(AGG_UNUSED, 1'b0);
      send_word(MODE_FEED, 10'd7, 64'sd3, 1'b1);
      send_word(MODE_READ, 10'd7, '0, 1'b0);
      send_word(MODE_UNUSED, 10'd7, VALUE_MAX, 1'b1);
      wait_for_drain();
   endtask

   // An optional init, a run of rows and a read on a few hot groups, with stray words in between.
   task automatic run_sequences(input int count);
      logic [GROUP_BITS-1:0] pool [4];
      logic [GROUP_BITS-1:0] g;
      int sent;
      int rows;
      foreach (pool[i]) pool[i] = GROUP_BITS'($urandom_range(0, GROUP_TOTAL - 1));
      sent = 0;
      while (sent < count) begin
         g = pool[$urandom_range(0, 3)];
         if ($urandom_range(0, 3) != 0) begin
            send_word(MODE_INIT, g, draw_value(), 1'($urandom_range(0, 1)));
            sent++;
         end
         rows = $urandom_range(1, 5);
         repeat (rows) begin
            if ($urandom_range(0, 4) == 0)
               send_word(MODE_BITS'($urandom_range(0, 3)),
                         GROUP_BITS'($urandom_range(0, GROUP_TOTAL - 1)),
                         draw_value(), 1'($urandom_range(0, 1)));
            else
               send_word(MODE_FEED, g, draw_value(), $urandom_range(0, 7) != 0);
            sent++;
         end
         send_word(MODE_READ, g, draw_value(), 1'($urandom_range(0, 1)));
         sent++;
      end
   endtask

   // Every aggregate with both drop-missing settings, plus a random unused kind in each round.
   task automatic test_random_streams();
      logic [KIND_BITS-1:0] kind;
      for (int round = 0; round < 2; round++) begin
         for (int k = 0; k < 11; k++) begin
            kind = (k < 10) ? KIND_BITS'(k) : KIND_BITS'($urandom_range(10, 15));
            no_gaps = ($urandom_range(0, 3) == 0);
            set_config(kind, 1'(k % 2) ^ 1'(round));
            run_sequences(16);
            wait_for_drain();
         end
      end
      no_gaps = 1'b0;
   endtask

   // The result side holds off while reads keep coming, so the core must stall its input.
   task automatic test_backpressure();
      set_config(AGG_COUNT_VALID, 1'b0);
      no_gaps = 1'b1;
      rsp_hold_cycles = 60;
      repeat (30) begin
         if ($urandom_range(0, 3) == 0)
            send_word(MODE_FEED, GROUP_BITS'($urandom_range(0, 3)), draw_value(),
                      1'($urandom_range(0, 1)));
         else
            send_word(MODE_READ, GROUP_BITS'($urandom_range(0, 3)), draw_value(), 1'b0);
      end
      wait_for_drain();
      no_gaps = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < GROUP_TOTAL; i++) begin
         grp_count[i]  = '0;
         grp_accum[i]  = '0;
         grp_flag[i]   = 1'b0;
         grp_poison[i] = 1'b0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      reset_released = 1'b1;

      test_register_defaults();
      test_directed_cases();
      test_random_streams();
      test_backpressure();

      wait_for_drain();
      if (expected_reads.size() != 0) begin
         report_mismatch($sformatf("%0d result words never arrived", expected_reads.size()));
      end
      if (mismatch_count == 0) begin
         $display("grouped_aggregate_accumulator_core verification clean");
      end else begin
         $display("grouped_aggregate_accumulator_core verification failed");
      end
      $finish;
   end

endmodule
